// File: hdl/ssi_pkg.sv
// types and helpers for the segment versus square intersection core
package ssi_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned HalfW  = 23;
    localparam int unsigned DivSteps = 24;

    typedef struct packed {
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic signed [CoordW-1:0] center_x;
        logic signed [CoordW-1:0] center_y;
        logic        [HalfW-1:0]  half_side;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] hit_x;
        logic signed [CoordW-1:0] hit_y;
    } t_rsp;

    // one edge under test
    typedef struct packed {
        logic                     ok;
        logic signed [25:0]       ea;
        logic signed [CoordW-1:0] b;
        logic signed [CoordW-1:0] cb;
        logic                     neg;
        logic        [CoordW-1:0] d;
    } t_edge;

    typedef struct packed {
        logic                     inside_hit;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic        [HalfW-1:0]  s;
        t_edge                    e0;
        t_edge                    e1;
    } t_meta;

    typedef struct packed {
        logic [CoordW-1:0] rem;
        logic [CoordW-1:0] low;
        logic [CoordW-1:0] q;
    } t_div;

endpackage

// File: hdl/segment_square_intersection_core.sv
// segment versus axis-aligned square first contact, pipelined
// Takes one request per cycle while o_ready is high and returns one response per request, in
// order; o_valid rises as the response leaves the output register (27 register stages).
// The depth is set by the two parallel restoring dividers, one quotient bit per stage over
// 24 stages, behind a prepare stage and a multiply stage and ahead of the output register; a
// stall at the output freezes the whole pipeline without loss.
module segment_square_intersection_core
    import ssi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    function automatic t_edge edge_prep(input logic signed [23:0] a,
                                        input logic signed [23:0] b,
                                        input logic signed [23:0] ca,
                                        input logic signed [23:0] cb,
                                        input logic signed [24:0] s);
        t_edge                e;
        logic signed [25:0]   a26;
        logic signed [24:0]   amag;
        a26  = 26'(a);
        e.ea = (a > 0) ? (26'(ca) - 26'(s)) : (26'(ca) + 26'(s));
        e.ok = (a != '0) && (((a26 >= e.ea) && (e.ea >= 0)) ||
                             ((a26 <= e.ea) && (e.ea <= 0)));
        e.b   = b;
        e.cb  = cb;
        e.neg = e.ea[25] ^ b[23] ^ a[23];
        amag  = a[23] ? -25'(a) : 25'(a);
        e.d   = amag[23:0];
        return e;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic t_div div_step(input t_div x, input logic [23:0] d);
        t_div        y;
        logic [24:0] t;
        logic        ge;
        t     = {x.rem, x.low[23]};
        ge    = (t >= {1'b0, d});
        y.rem = ge ? 24'(t - {1'b0, d}) : t[23:0];
        y.low = {x.low[22:0], 1'b0};
        y.q   = {x.q[22:0], ge};
        return y;
    endfunction

    logic en;

    // prepare stage
    logic  r_va;
    t_meta r_ma;
    t_meta n_ma;

    // multiply stage
    logic        r_vb;
    t_meta       r_mb;
    logic [47:0] r_p0;
    logic [47:0] r_p1;

    // divider stages
    logic  r_vd [0:DivSteps-1];
    t_meta r_md [0:DivSteps-1];
    t_div  r_d0 [0:DivSteps-1];
    t_div  r_d1 [0:DivSteps-1];

    logic r_vo;
    t_rsp r_rsp;
    t_rsp n_rsp;

    assign en      = !r_vo || i_ready;
    assign o_ready = en;
    assign o_valid = r_vo;
    assign o_rsp   = r_rsp;

    always_comb begin
        logic signed [24:0] s;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               org_in;
        logic               end_in;
        logic signed [24:0] s_eff;
        s      = 25'($unsigned(i_req.half_side));
        dx     = 25'(i_req.end_x) - 25'(i_req.center_x);
        dy     = 25'(i_req.end_y) - 25'(i_req.center_y);
        org_in = (25'(i_req.center_x) <= s) && (25'(i_req.center_x) >= -s) &&
                 (25'(i_req.center_y) <= s) && (25'(i_req.center_y) >= -s);
        end_in = (dx <= s) && (dx >= -s) && (dy <= s) && (dy >= -s);
        s_eff  = (org_in && !end_in) ? -s : s;
        n_ma.inside_hit = org_in && end_in;
        n_ma.ex = i_req.end_x;
        n_ma.ey = i_req.end_y;
        n_ma.s  = i_req.half_side;
        n_ma.e0 = edge_prep(i_req.end_y, i_req.end_x, i_req.center_y, i_req.center_x, s_eff);
        n_ma.e1 = edge_prep(i_req.end_x, i_req.end_y, i_req.center_x, i_req.center_y, s_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [49:0] p0;
        logic signed [49:0] p1;
        if (en) begin
            r_ma <= n_ma;
            p0 = r_ma.e0.ea * 50'(r_ma.e0.b);
            p1 = r_ma.e1.ea * 50'(r_ma.e1.b);
            r_mb <= r_ma;
            r_p0 <= p0[49] ? 48'(-p0) : p0[47:0];
            r_p1 <= p1[49] ? 48'(-p1) : p1[47:0];
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                t_div x0;
                t_div x1;
                if (!i_rst_n) begin
                    r_vd[k] <= 1'b0;
                end else if (en) begin
                    r_vd[k] <= r_vb;
                end
                if (en) begin
                    x0 = '{rem: r_p0[47:24], low: r_p0[23:0], q: '0};
                    x1 = '{rem: r_p1[47:24], low: r_p1[23:0], q: '0};
                    r_md[k] <= r_mb;
                    r_d0[k] <= div_step(x0, r_mb.e0.d);
                    r_d1[k] <= div_step(x1, r_mb.e1.d);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd[k] <= 1'b0;
                end else if (en) begin
                    r_vd[k] <= r_vd[k-1];
                end
                if (en) begin
                    r_md[k] <= r_md[k-1];
                    r_d0[k] <= div_step(r_d0[k-1], r_md[k-1].e0.d);
                    r_d1[k] <= div_step(r_d1[k-1], r_md[k-1].e1.d);
                end
            end
        end
    end

    always_comb begin
        t_meta              m;
        logic signed [25:0] eb0;
        logic signed [25:0] eb1;
        logic signed [26:0] df0;
        logic signed [26:0] df1;
        logic signed [26:0] sm;
        logic               h0;
        logic               h1;
        m   = r_md[DivSteps-1];
        eb0 = m.e0.neg ? -26'($unsigned(r_d0[DivSteps-1].q)) :
                          26'($unsigned(r_d0[DivSteps-1].q));
        eb1 = m.e1.neg ? -26'($unsigned(r_d1[DivSteps-1].q)) :
                          26'($unsigned(r_d1[DivSteps-1].q));
        df0 = 27'(eb0) - 27'(m.e0.cb);
        df1 = 27'(eb1) - 27'(m.e1.cb);
        sm  = 27'($unsigned(m.s));
        h0  = m.e0.ok && (df0 <= sm) && (df0 >= -sm);
        h1  = m.e1.ok && (df1 <= sm) && (df1 >= -sm);
        if (m.inside_hit) begin
            n_rsp = '{hit: 1'b1, hit_x: m.ex, hit_y: m.ey};
        end else if (h0) begin
            // horizontal edge: y is the edge, x from the quotient
            n_rsp = '{hit: 1'b1, hit_x: sat24(eb0), hit_y: sat24(m.e0.ea)};
        end else if (h1) begin
            n_rsp = '{hit: 1'b1, hit_x: sat24(m.e1.ea), hit_y: sat24(eb1)};
        end else begin
            n_rsp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vd[DivSteps-1];
        end
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
